// ===== rtl/core/pmb_pkg.sv =====
// Shared types and constants of the paged I2C slave mailbox.
package pmb_pkg;

  typedef logic [7:0] byte_t;

  typedef enum logic [2:0] {
    KIND_WRITE_START = 3'd0,
    KIND_READ_START  = 3'd1,
    KIND_RX_BYTE     = 3'd2,
    KIND_TX_EMPTY    = 3'd3,
    KIND_STOP        = 3'd4,
    KIND_LOAD_PAGE   = 3'd5,
    KIND_READ_RX     = 3'd6,
    KIND_SET_PAGE    = 3'd7
  } kind_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_FETCH = 1'b1
  } state_t;

  // What the result of a pending item is made of once memory data returns.
  typedef struct packed {
    logic tx_valid;
    logic use_page;
    logic use_rx;
  } pend_t;

  localparam byte_t MAX_REPLY = 8'd64;
  localparam byte_t IDLE_BYTE = 8'hFF;

endpackage

// ===== rtl/core/i2c_slave_paged_mailbox.sv =====
// Byte-level data engine of an I2C slave with a paged transmit store.
// An item is accepted on a clock edge with start high and busy low; its result
// is registered onto the output ports, marked by done, at the end of the fetch state.
// No new item is accepted while busy: busy covers the cycle in which the page or
// receive memory returns its synchronously read byte. Synchronous rst clears offsets,
// reply length, current page and the finished flag; the memories keep their contents.
module i2c_slave_paged_mailbox #(
  parameter int BUF_LEN   = 64,
  parameter int NUM_PAGES = 133
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  output logic       done,
  input  logic [2:0] kind,
  input  logic [7:0] data_byte,
  input  logic [7:0] page,
  input  logic [5:0] position,
  output logic       tx_valid,
  output logic [7:0] tx_byte,
  output logic [7:0] rx_read_byte,
  output logic       finished
);

  localparam int OW    = $clog2(BUF_LEN);
  localparam int PDEP  = NUM_PAGES * BUF_LEN;
  localparam int PAW   = (PDEP > 1) ? $clog2(PDEP) : 1;
  localparam int PW    = PAW + 8;

  pmb_pkg::state_t state, state_next;
  logic            fetch;
  logic            acc;

  logic [6:0]      reply_length, reply_length_next;
  logic [7:0]      current_page, current_page_next;
  logic [OW-1:0]   in_offset, in_offset_next;
  logic [OW-1:0]   out_offset, out_offset_next;
  logic            finish_flag, finish_flag_next;
  pmb_pkg::pend_t  pend, pend_next;

  logic [OW-1:0]   in_inc, out_inc, pos_off;
  logic [8:0]      pos_ext;
  logic            pos_ok, page_ok, data_page_ok;

  logic            page_we, page_sel_load;
  logic [7:0]      pg_sel;
  logic [OW-1:0]   off_sel;
  logic [PW-1:0]   page_prod;
  logic [PAW-1:0]  page_addr;
  pmb_pkg::byte_t  page_rdata;

  logic            rx_we;
  logic [OW-1:0]   rx_addr;
  pmb_pkg::byte_t  rx_rdata;

  // Control FSM: next state.
  always_comb begin
    state_next = state;
    case (state)
      pmb_pkg::ST_IDLE:  if (start) state_next = pmb_pkg::ST_FETCH;
      pmb_pkg::ST_FETCH: state_next = pmb_pkg::ST_IDLE;
      default:           state_next = pmb_pkg::ST_IDLE;
    endcase
  end

  // Control FSM: outputs.
  always_comb begin
    busy  = 1'b0;
    fetch = 1'b0;
    case (state)
      pmb_pkg::ST_IDLE:  busy = 1'b0;
      pmb_pkg::ST_FETCH: begin
        busy  = 1'b1;
        fetch = 1'b1;
      end
      default:           busy = 1'b0;
    endcase
  end

  assign acc = start & ~busy;

  assign in_inc  = (in_offset == OW'(BUF_LEN - 1)) ? '0 : in_offset + OW'(1);
  assign out_inc = (out_offset == OW'(BUF_LEN - 1)) ? '0 : out_offset + OW'(1);
  assign pos_ext = 9'(position);
  assign pos_off = pos_ext[OW-1:0];
  assign pos_ok  = pos_ext < 9'(BUF_LEN);
  assign page_ok = 9'(page) < 9'(NUM_PAGES);
  assign data_page_ok = 9'(data_byte) < 9'(NUM_PAGES);

  // Item decode: all register updates and memory writes happen at acceptance;
  // the memory read issued in the same cycle returns during the fetch cycle.
  always_comb begin
    reply_length_next = reply_length;
    current_page_next = current_page;
    in_offset_next    = in_offset;
    out_offset_next   = out_offset;
    finish_flag_next  = finish_flag;
    pend_next         = '0;
    page_we           = 1'b0;
    page_sel_load     = 1'b0;
    rx_we             = 1'b0;
    rx_addr           = pos_off;
    if (acc) begin
      case (pmb_pkg::kind_t'(kind))
        pmb_pkg::KIND_READ_START: begin
          pend_next.tx_valid = 1'b1;
          pend_next.use_page = 1'b1;
          out_offset_next    = out_inc;
        end
        pmb_pkg::KIND_RX_BYTE: begin
          rx_we   = 1'b1;
          rx_addr = in_offset;
          if (in_offset == '0 && data_byte <= pmb_pkg::MAX_REPLY) begin
            reply_length_next = data_byte[6:0];
          end
          if (in_offset == OW'(1) && data_page_ok) begin
            current_page_next = data_byte;
          end
          in_offset_next = in_inc;
        end
        pmb_pkg::KIND_TX_EMPTY: begin
          pend_next.tx_valid = 1'b1;
          if (9'(out_offset) < 9'(reply_length)) begin
            pend_next.use_page = 1'b1;
            out_offset_next    = out_inc;
          end
        end
        pmb_pkg::KIND_STOP: begin
          in_offset_next   = '0;
          out_offset_next  = '0;
          finish_flag_next = 1'b1;
        end
        pmb_pkg::KIND_LOAD_PAGE: begin
          page_sel_load = 1'b1;
          page_we       = page_ok & pos_ok;
        end
        pmb_pkg::KIND_READ_RX: begin
          pend_next.use_rx = pos_ok;
        end
        pmb_pkg::KIND_SET_PAGE: begin
          if (page_ok) current_page_next = page;
        end
        pmb_pkg::KIND_WRITE_START: begin
          pend_next = '0;
        end
        default: begin
          pend_next = '0;
        end
      endcase
    end
  end

  // Page address: a software load uses its own page and position, a send uses
  // the selected page and the read offset.
  assign pg_sel    = page_sel_load ? page : current_page;
  assign off_sel   = page_sel_load ? pos_off : out_offset;
  assign page_prod = PW'(pg_sel) * PW'(BUF_LEN);
  assign page_addr = page_prod[PAW-1:0] + PAW'(off_sel);

  pmb_ram #(
    .DEPTH (PDEP),
    .AW    (PAW)
  ) u_page_ram (
    .clk   (clk),
    .we    (page_we),
    .addr  (page_addr),
    .wdata (data_byte),
    .rdata (page_rdata)
  );

  pmb_ram #(
    .DEPTH (BUF_LEN),
    .AW    (OW)
  ) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .addr  (rx_addr),
    .wdata (data_byte),
    .rdata (rx_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= pmb_pkg::ST_IDLE;
      done         <= 1'b0;
      reply_length <= '0;
      current_page <= '0;
      in_offset    <= '0;
      out_offset   <= '0;
      finish_flag  <= 1'b0;
    end else begin
      state        <= state_next;
      done         <= fetch;
      reply_length <= reply_length_next;
      current_page <= current_page_next;
      in_offset    <= in_offset_next;
      out_offset   <= out_offset_next;
      finish_flag  <= finish_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      pend <= pend_next;
    end
    if (fetch) begin
      tx_valid     <= pend.tx_valid;
      tx_byte      <= pend.use_page ? page_rdata :
                      (pend.tx_valid ? pmb_pkg::IDLE_BYTE : 8'd0);
      rx_read_byte <= pend.use_rx ? rx_rdata : 8'd0;
      finished     <= finish_flag;
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the block busy");

  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> (done && !busy))
    else $error("fetch cycle was not followed by a result");

  a_done_once: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe lasted more than one cycle");

endmodule

// ===== rtl/core/pmb_ram.sv =====
// Byte-wide single-port synchronous RAM with registered read data.
module pmb_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   addr,
  input  pmb_pkg::byte_t  wdata,
  output pmb_pkg::byte_t  rdata
);

  pmb_pkg::byte_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== test/i2c_slave_paged_mailbox_tb.sv =====
// Self-checking testbench for the paged I2C slave mailbox data engine.
module i2c_slave_paged_mailbox_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BUF_LEN   = 64;
  localparam int NUM_PAGES = 133;
  localparam int ITEM_GOAL = 1850;
  localparam int CHUNK     = 300;
  localparam int LIMIT     = 200000;

  typedef struct packed {
    logic           tx_valid;
    pmb_pkg::byte_t tx_byte;
    pmb_pkg::byte_t rx_byte;
    logic           fin;
  } mbox_result_t;

  typedef struct {
    pmb_pkg::kind_t kind;
    pmb_pkg::byte_t data;
    pmb_pkg::byte_t page;
    logic [5:0]     pos;
    mbox_result_t   want;
  } mbox_item_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic [2:0] kind = '0;
  logic [7:0] data_byte = '0;
  logic [7:0] page = '0;
  logic [5:0] position = '0;
  logic       busy;
  logic       done;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic [7:0] rx_read_byte;
  logic       finished;

  i2c_slave_paged_mailbox #(
    .BUF_LEN  (BUF_LEN),
    .NUM_PAGES(NUM_PAGES)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .kind        (kind),
    .data_byte   (data_byte),
    .page        (page),
    .position    (position),
    .tx_valid    (tx_valid),
    .tx_byte     (tx_byte),
    .rx_read_byte(rx_read_byte),
    .finished    (finished)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mailbox state as the items queued so far leave it.
  pmb_pkg::byte_t page_mem [NUM_PAGES*BUF_LEN];
  bit             page_ok  [NUM_PAGES*BUF_LEN];
  pmb_pkg::byte_t rx_mem   [BUF_LEN];
  bit             rx_ok    [BUF_LEN];
  logic [6:0]     m_reply = '0;
  pmb_pkg::byte_t m_page = '0;
  logic [5:0]     m_in = '0;
  logic [5:0]     m_out = '0;
  logic           m_fin = 1'b0;

  mbox_item_t   bus_events_q[$];
  mbox_result_t results_due_q[$];
  mbox_item_t   cur_item;
  bit           have_item = 1'b0;
  bit           took = 1'b0;
  bit           no_idle = 1'b0;
  int           gap_left = 0;
  int           n_items = 0;
  int           mismatches = 0;
  int           cycles = 0;

  function automatic pmb_pkg::byte_t rnd8();
    return pmb_pkg::byte_t'($urandom_range(0, 255));
  endfunction

  function automatic pmb_pkg::byte_t hot_page();
    case ($urandom_range(0, 6))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd2;
      3: return 8'd3;
      4: return 8'd64;
      5: return 8'd131;
      default: return 8'd132;
    endcase
  endfunction

  // Next byte of the selected page; the read offset wraps at the buffer length.
  function automatic pmb_pkg::byte_t page_fetch();
    pmb_pkg::byte_t b;
    b = page_mem[int'(m_page)*BUF_LEN + int'(m_out)];
    m_out = m_out + 1'b1;
    return b;
  endfunction

  function automatic mbox_result_t mailbox_apply(mbox_item_t it);
    mbox_result_t r;
    int idx;
    r = '0;
    case (it.kind)
      pmb_pkg::KIND_READ_START: begin
        r.tx_valid = 1'b1;
        r.tx_byte  = page_fetch();
      end
      pmb_pkg::KIND_RX_BYTE: begin
        rx_mem[m_in] = it.data;
        rx_ok[m_in]  = 1'b1;
        if (m_in == 6'd0 && it.data <= pmb_pkg::MAX_REPLY) m_reply = it.data[6:0];
        if (m_in == 6'd1 && it.data < NUM_PAGES) m_page = it.data;
        m_in = m_in + 1'b1;
      end
      pmb_pkg::KIND_TX_EMPTY: begin
        r.tx_valid = 1'b1;
        r.tx_byte  = ({1'b0, m_out} < m_reply) ? page_fetch() : pmb_pkg::IDLE_BYTE;
      end
      pmb_pkg::KIND_STOP: begin
        m_in  = '0;
        m_out = '0;
        m_fin = 1'b1;
      end
      pmb_pkg::KIND_LOAD_PAGE: begin
        if (it.page < NUM_PAGES) begin
          idx = int'(it.page)*BUF_LEN + int'(it.pos);
          page_mem[idx] = it.data;
          page_ok[idx]  = 1'b1;
        end
      end
      pmb_pkg::KIND_READ_RX: r.rx_byte = rx_mem[it.pos];
      pmb_pkg::KIND_SET_PAGE: begin
        if (it.page < NUM_PAGES) m_page = it.page;
      end
      default: ;
    endcase
    r.fin = m_fin;
    return r;
  endfunction

  function automatic void put_raw(pmb_pkg::kind_t k, pmb_pkg::byte_t d, pmb_pkg::byte_t p,
                                  logic [5:0] q);
    mbox_item_t it;
    it.kind = k;
    it.data = d;
    it.page = p;
    it.pos  = q;
    it.want = mailbox_apply(it);
    bus_events_q.push_back(it);
    n_items++;
  endfunction

  // Queues an item, first loading any page byte it would send that was never written.
  // A receive read is moved to a written position, or dropped if there is none.
  function automatic void put(pmb_pkg::kind_t k, pmb_pkg::byte_t d, pmb_pkg::byte_t p,
                              logic [5:0] q);
    int idx;
    int j;
    if (k == pmb_pkg::KIND_READ_START ||
        (k == pmb_pkg::KIND_TX_EMPTY && {1'b0, m_out} < m_reply)) begin
      idx = int'(m_page)*BUF_LEN + int'(m_out);
      if (!page_ok[idx]) put_raw(pmb_pkg::KIND_LOAD_PAGE, rnd8(), m_page, m_out);
    end
    if (k == pmb_pkg::KIND_READ_RX) begin
      j = 0;
      while (j < BUF_LEN && !rx_ok[q]) begin
        q = q + 1'b1;
        j++;
      end
      if (!rx_ok[q]) return;
    end
    put_raw(k, d, p, q);
  endfunction

  function automatic void write_burst();
    int n;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 6);
    put(pmb_pkg::KIND_WRITE_START, rnd8(), rnd8(), 6'($urandom));
    for (int i = 0; i < n; i++) begin
      if (i == 0)
        put(pmb_pkg::KIND_RX_BYTE,
            ($urandom_range(0, 3) != 0) ? pmb_pkg::byte_t'($urandom_range(0, 64)) : rnd8(),
            rnd8(), 6'($urandom));
      else if (i == 1)
        put(pmb_pkg::KIND_RX_BYTE, ($urandom_range(0, 4) != 0) ? hot_page() : rnd8(),
            rnd8(), 6'($urandom));
      else
        put(pmb_pkg::KIND_RX_BYTE, rnd8(), rnd8(), 6'($urandom));
    end
    if ($urandom_range(0, 99) < 85) put(pmb_pkg::KIND_STOP, rnd8(), rnd8(), 6'($urandom));
  endfunction

  function automatic void read_burst();
    int n;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(66, 70) : $urandom_range(1, 12);
    put(pmb_pkg::KIND_READ_START, rnd8(), rnd8(), 6'($urandom));
    for (int i = 0; i < n; i++) put(pmb_pkg::KIND_TX_EMPTY, rnd8(), rnd8(), 6'($urandom));
    if ($urandom_range(0, 99) < 85) put(pmb_pkg::KIND_STOP, rnd8(), rnd8(), 6'($urandom));
  endfunction

  function automatic void page_fill();
    pmb_pkg::byte_t p;
    logic [5:0]     q;
    int             n;
    p = ($urandom_range(0, 9) != 0) ? hot_page() : rnd8();
    q = 6'($urandom);
    n = $urandom_range(1, 16);
    for (int i = 0; i < n; i++) begin
      put(pmb_pkg::KIND_LOAD_PAGE, rnd8(), p, q);
      q = q + 1'b1;
    end
  endfunction

  function automatic void random_chunk();
    int goal;
    int r;
    goal = n_items + CHUNK;
    while (n_items < goal) begin
      r = $urandom_range(0, 99);
      if (r < 33)
        write_burst();
      else if (r < 66)
        read_burst();
      else if (r < 78)
        page_fill();
      else if (r < 84)
        put(pmb_pkg::KIND_READ_RX, rnd8(), rnd8(), 6'($urandom));
      else if (r < 90)
        put(pmb_pkg::KIND_SET_PAGE, rnd8(),
            ($urandom_range(0, 2) != 0) ? hot_page() : rnd8(), 6'($urandom));
      else
        put(pmb_pkg::kind_t'(3'($urandom_range(0, 7))), rnd8(), rnd8(), 6'($urandom));
    end
  endfunction

  task automatic wait_drained();
    while (bus_events_q.size() != 0 || have_item || results_due_q.size() != 0)
      @(posedge clk);
  endtask

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Driver: presents queued items at the falling edge, idling between them at random.
  always @(negedge clk) begin
    if (!rst) begin
      if (took) begin
        took = 1'b0;
        have_item = 1'b0;
      end
      if (!have_item) begin
        if (gap_left != 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (bus_events_q.size() != 0) begin
          cur_item = bus_events_q.pop_front();
          have_item = 1'b1;
          start <= 1'b1;
          kind <= cur_item.kind;
          data_byte <= cur_item.data;
          page <= cur_item.page;
          position <= cur_item.pos;
          gap_left = no_idle ? 0 : $urandom_range(0, 8);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: results are matched before the item accepted at this edge is queued,
  // since a result never belongs to the item accepted on the same edge.
  always @(posedge clk) begin
    mbox_result_t want;
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
    if (!rst) begin
      if (done) begin
        if (results_due_q.size() == 0) begin
          $display("%0t ns: unexpected result, tx_valid %b tx_byte 0x%0h rx 0x%0h fin %b",
                   $time, tx_valid, tx_byte, rx_read_byte, finished);
          mismatches++;
        end else begin
          want = results_due_q.pop_front();
          check_field("tx_valid", {7'd0, want.tx_valid}, {7'd0, tx_valid});
          check_field("tx_byte", want.tx_byte, tx_byte);
          check_field("rx_read_byte", want.rx_byte, rx_read_byte);
          check_field("finished", {7'd0, want.fin}, {7'd0, finished});
        end
      end
      if (start && !busy) begin
        results_due_q.push_back(cur_item.want);
        took = 1'b1;
      end
    end
  end

  initial begin
    // Reply length and page limits at both sides, then reads around them.
    put(pmb_pkg::KIND_WRITE_START, 8'h00, 8'h00, 6'd0);
    put(pmb_pkg::KIND_RX_BYTE, 8'd64, 8'h00, 6'd0);
    put(pmb_pkg::KIND_RX_BYTE, 8'd132, 8'h00, 6'd0);
    put(pmb_pkg::KIND_RX_BYTE, 8'hFF, 8'hFF, 6'd63);
    put(pmb_pkg::KIND_STOP, 8'h00, 8'h00, 6'd0);
    put(pmb_pkg::KIND_WRITE_START, 8'hFF, 8'hFF, 6'd63);
    put(pmb_pkg::KIND_RX_BYTE, 8'd65, 8'h00, 6'd0);
    put(pmb_pkg::KIND_RX_BYTE, 8'd133, 8'h00, 6'd0);
    put(pmb_pkg::KIND_RX_BYTE, 8'h00, 8'h00, 6'd0);
    put(pmb_pkg::KIND_STOP, 8'hFF, 8'hFF, 6'd63);
    put(pmb_pkg::KIND_LOAD_PAGE, 8'hA5, 8'd132, 6'd0);
    put(pmb_pkg::KIND_LOAD_PAGE, 8'h5A, 8'd132, 6'd63);
    put(pmb_pkg::KIND_LOAD_PAGE, 8'h3C, 8'd255, 6'd7);
    put(pmb_pkg::KIND_LOAD_PAGE, 8'hC3, 8'd133, 6'd0);
    put(pmb_pkg::KIND_LOAD_PAGE, 8'h00, 8'd0, 6'd0);
    put(pmb_pkg::KIND_SET_PAGE, 8'h00, 8'd255, 6'd0);
    put(pmb_pkg::KIND_READ_START, 8'h00, 8'h00, 6'd0);
    put(pmb_pkg::KIND_TX_EMPTY, 8'h00, 8'h00, 6'd0);
    put(pmb_pkg::KIND_READ_RX, 8'h00, 8'h00, 6'd0);
    put(pmb_pkg::KIND_READ_RX, 8'h00, 8'h00, 6'd2);
    put(pmb_pkg::KIND_SET_PAGE, 8'h00, 8'd0, 6'd0);
    put(pmb_pkg::KIND_STOP, 8'h00, 8'h00, 6'd0);
    put(pmb_pkg::KIND_WRITE_START, 8'h00, 8'h00, 6'd0);
    put(pmb_pkg::KIND_RX_BYTE, 8'd0, 8'h00, 6'd0);
    put(pmb_pkg::KIND_STOP, 8'h00, 8'h00, 6'd0);
    put(pmb_pkg::KIND_READ_START, 8'h00, 8'h00, 6'd0);
    put(pmb_pkg::KIND_TX_EMPTY, 8'h00, 8'h00, 6'd0);

    repeat (3) @(negedge clk);
    rst <= 1'b0;
    wait_drained();

    // Random part in chunks; the sender holds off until the block has drained after each.
    for (int c = 0; n_items < ITEM_GOAL; c++) begin
      no_idle = (c % 3 == 1);
      random_chunk();
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
